// ----- rtl/core/scb_pkg.sv -----
// scb_pkg: shared constants, types and the scancode translation table
// for the scancode line buffer
// no dependencies

package scb_pkg;

	// ring geometry
	localparam int DEPTH = 256;
	localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [6:0]       char_t;

	// operation codes on the request channel
	localparam logic OP_KEY  = 1'b0;
	localparam logic OP_READ = 1'b1;

	// character codes
	localparam char_t CH_NONE = 7'h00;
	localparam char_t CH_BKSP = 7'h08;

	// requests from the top level to the ring store
	typedef struct packed {
		logic wr;   // append a character at the tail
		logic del;  // drop the newest character
		logic rd;   // pop the oldest character
	} ring_req_t;

	// status from the ring store
	typedef struct packed {
		logic empty;
	} ring_sts_t;

	// pointer step forwards with wrap
	function automatic ptr_t ring_next(input ptr_t p);
		ring_next = (p == ptr_t'(DEPTH - 1)) ? '0 : ptr_t'(p + 1'b1);
	endfunction

	// pointer step backwards with wrap
	function automatic ptr_t ring_prev(input ptr_t p);
		ring_prev = (p == '0) ? ptr_t'(DEPTH - 1) : ptr_t'(p - 1'b1);
	endfunction

	// us set-1 make code to ascii, zero where the key gives no character
	function automatic char_t key_ascii(input logic [6:0] code);
		case (code)
			7'h01: key_ascii = 7'h1B;
			7'h02: key_ascii = 7'h31;
			7'h03: key_ascii = 7'h32;
			7'h04: key_ascii = 7'h33;
			7'h05: key_ascii = 7'h34;
			7'h06: key_ascii = 7'h35;
			7'h07: key_ascii = 7'h36;
			7'h08: key_ascii = 7'h37;
			7'h09: key_ascii = 7'h38;
			7'h0A: key_ascii = 7'h39;
			7'h0B: key_ascii = 7'h30;
			7'h0C: key_ascii = 7'h2D;
			7'h0D: key_ascii = 7'h3D;
			7'h0E: key_ascii = CH_BKSP;
			7'h0F: key_ascii = 7'h09;
			7'h10: key_ascii = 7'h71;
			7'h11: key_ascii = 7'h77;
			7'h12: key_ascii = 7'h65;
			7'h13: key_ascii = 7'h72;
			7'h14: key_ascii = 7'h74;
			7'h15: key_ascii = 7'h79;
			7'h16: key_ascii = 7'h75;
			7'h17: key_ascii = 7'h69;
			7'h18: key_ascii = 7'h6F;
			7'h19: key_ascii = 7'h70;
			7'h1A: key_ascii = 7'h5B;
			7'h1B: key_ascii = 7'h5D;
			7'h1C: key_ascii = 7'h0A;
			7'h1E: key_ascii = 7'h61;
			7'h1F: key_ascii = 7'h73;
			7'h20: key_ascii = 7'h64;
			7'h21: key_ascii = 7'h66;
			7'h22: key_ascii = 7'h67;
			7'h23: key_ascii = 7'h68;
			7'h24: key_ascii = 7'h6A;
			7'h25: key_ascii = 7'h6B;
			7'h26: key_ascii = 7'h6C;
			7'h27: key_ascii = 7'h3B;
			7'h28: key_ascii = 7'h27;
			7'h29: key_ascii = 7'h60;
			7'h2B: key_ascii = 7'h5C;
			7'h2C: key_ascii = 7'h7A;
			7'h2D: key_ascii = 7'h78;
			7'h2E: key_ascii = 7'h63;
			7'h2F: key_ascii = 7'h76;
			7'h30: key_ascii = 7'h62;
			7'h31: key_ascii = 7'h6E;
			7'h32: key_ascii = 7'h6D;
			7'h33: key_ascii = 7'h2C;
			7'h34: key_ascii = 7'h2E;
			7'h35: key_ascii = 7'h2F;
			7'h37: key_ascii = 7'h2A;
			7'h39: key_ascii = 7'h20;
			default: key_ascii = CH_NONE;
		endcase
	endfunction

endpackage

// ----- rtl/core/scb_if.sv -----
// scb_req_if and scb_rsp_if: valid/ready channels of the scancode line buffer
// depends on scb_pkg

// request channel: scancode event or read
interface scb_req_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] scancode;

	modport source (output valid, output op, output scancode, input ready);
	modport sink (input valid, input op, input scancode, output ready);
endinterface

// response channel: popped character
interface scb_rsp_if;
	logic            valid;
	logic            ready;
	scb_pkg::char_t  char_out;
	logic            was_empty;

	modport source (output valid, output char_out, output was_empty, input ready);
	modport sink (input valid, input char_out, input was_empty, output ready);
endinterface

// ----- rtl/core/scb_ring.sv -----
// scb_ring: character ring memory with read and write pointers
// depends on scb_pkg

module scb_ring (
	input  logic               clk,
	input  logic               arst_n,
	input  scb_pkg::ring_req_t req,
	input  scb_pkg::char_t     wr_char,
	output scb_pkg::ring_sts_t sts,
	output scb_pkg::char_t     rd_char
);

	scb_pkg::char_t mem [scb_pkg::DEPTH];
	scb_pkg::ptr_t  rd_ptr_q;
	scb_pkg::ptr_t  wr_ptr_q;
	scb_pkg::ptr_t  wr_next;

	assign wr_next   = scb_pkg::ring_next(wr_ptr_q);
	assign sts.empty = (rd_ptr_q == wr_ptr_q);

	// memory write at the tail, registered read at the head
	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[wr_ptr_q] <= wr_char;
		end
		if (req.rd) begin
			rd_char <= mem[rd_ptr_q];
		end
	end

	// pointer update; an append that catches up the head drops the oldest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
		end else begin
			if (req.wr) begin
				wr_ptr_q <= wr_next;
				if (wr_next == rd_ptr_q) begin
					rd_ptr_q <= scb_pkg::ring_next(rd_ptr_q);
				end
			end else if (req.del) begin
				wr_ptr_q <= scb_pkg::ring_prev(wr_ptr_q);
			end else if (req.rd) begin
				rd_ptr_q <= scb_pkg::ring_next(rd_ptr_q);
			end
		end
	end

endmodule

// ----- rtl/core/scancode_line_buffer.sv -----
// scancode_line_buffer: set-1 scancode to ascii translation into a ring,
// popped one character per read request
// depends on scb_pkg, scb_req_if, scb_rsp_if and scb_ring
//
//   channel | dir | payload                | transfer
//   req     | in  | op, scancode           | req.valid && req.ready
//   rsp     | out | char_out, was_empty    | rsp.valid && rsp.ready
//
// a scancode event gives no response
// an empty read answers in the cycle after its transfer; a non-empty read answers
// via the registered read of the ring memory and then the response register
// req.ready is low in the cycle after a non-empty read and while a response waits
// unclaimed; otherwise scancode events and empty reads can follow every cycle
// reset clears both pointers and the response valid; the ring memory is not cleared

module scancode_line_buffer (
	input  logic    clk,
	input  logic    arst_n,
	scb_req_if.sink   req,
	scb_rsp_if.source rsp
);

	scb_pkg::ring_req_t ring_req;
	scb_pkg::ring_sts_t ring_sts;
	scb_pkg::char_t     key_ch;
	scb_pkg::char_t     rd_char;
	scb_pkg::char_t     char_q;
	logic               was_empty_q;
	logic               rsp_valid_q;
	logic               pend_q;
	logic               take;
	logic               key_take;
	logic               read_take;
	logic               key_live;

	// request handshake
	assign req.ready = !pend_q && (!rsp_valid_q || rsp.ready);
	assign take      = req.valid && req.ready;
	assign key_take  = take && (req.op == scb_pkg::OP_KEY);
	assign read_take = take && (req.op == scb_pkg::OP_READ);

	// translation; break codes and unmapped keys give nothing
	assign key_ch   = scb_pkg::key_ascii(req.scancode[6:0]);
	assign key_live = key_take && !req.scancode[7] && (key_ch != scb_pkg::CH_NONE);

	// ring commands; backspace on an empty ring is stored as a character
	always_comb begin
		ring_req.del = key_live && (key_ch == scb_pkg::CH_BKSP) && !ring_sts.empty;
		ring_req.wr  = key_live && !ring_req.del;
		ring_req.rd  = read_take && !ring_sts.empty;
	end

	scb_ring u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (ring_req),
		.wr_char (key_ch),
		.sts     (ring_sts),
		.rd_char (rd_char)
	);

	// response control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			pend_q <= ring_req.rd;
			if (pend_q || (read_take && ring_sts.empty)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (pend_q) begin
			char_q      <= rd_char;
			was_empty_q <= 1'b0;
		end else if (read_take && ring_sts.empty) begin
			char_q      <= scb_pkg::CH_NONE;
			was_empty_q <= 1'b1;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.char_out  = char_q;
	assign rsp.was_empty = was_empty_q;

endmodule

// ----- rtl/core/scb_checker.sv -----
// scb_checker: port-level checks of the scancode line buffer, and its bind
// depends on scb_pkg and scancode_line_buffer

module scb_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input logic           req_op,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input scb_pkg::char_t rsp_char_out,
	input logic           rsp_was_empty
);

	// a scancode transfer never raises a response
	a_key_no_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && req_op == scb_pkg::OP_KEY) |=> !$rose(rsp_valid))
		else $error("response raised by a scancode transfer");

	// an empty-ring response carries the zero character
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_was_empty) |-> (rsp_char_out == scb_pkg::CH_NONE))
		else $error("empty response with a non-zero character");

	// no request is taken while a response waits unclaimed
	a_no_take_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |-> !(req_valid && req_ready))
		else $error("request taken while the response stalls");

	// a read is followed at once by its response or by a closed request side
	a_read_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && req_op == scb_pkg::OP_READ) |=> (rsp_valid || !req_ready))
		else $error("read transfer left no trace");

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=>
			(rsp_valid && $stable(rsp_char_out) && $stable(rsp_was_empty)))
		else $error("stalled response changed");

endmodule

bind scancode_line_buffer scb_checker u_scb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.req_op        (req.op),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_char_out  (rsp.char_out),
	.rsp_was_empty (rsp.was_empty)
);
